// ----- hdl/mbps_pkg.sv -----
package mbps_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int PAT_BYTES       = 16;
   localparam int PAT_IDX_BITS    = 4;
   localparam int MASK_BITS       = 16;
   localparam int LEN_BITS        = 5;
   localparam int CFG_DATA_BITS   = 64;
   localparam int CSR_INDEX_BITS  = 4;
   localparam int OUT_OFFSET_BITS = 32;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH   = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CARE_MASK      = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 4'd3;

   localparam logic [LEN_BITS-1:0] LENGTH_RESET = 5'd1;

   // per-cell compare setup
   typedef struct packed {
      logic [BYTE_BITS-1:0] pat_byte;
      logic                 care;
      logic                 active;
   } cell_cfg_type;

endpackage

// ----- hdl/mbps_cell.sv -----
// One window position: holds a byte, hands it on when the chain shifts,
// and compares the byte moving in against its pattern byte.
module mbps_cell (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [mbps_pkg::BYTE_BITS-1:0]    byte_in,
   input  mbps_pkg::cell_cfg_type            cfg,
   output logic [mbps_pkg::BYTE_BITS-1:0]    byte_out,
   output logic                              hit
);

   logic [mbps_pkg::BYTE_BITS-1:0] byte_ff;
   logic [mbps_pkg::BYTE_BITS-1:0] byte_ff_in;

   assign byte_ff_in = shift_en ? byte_in : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_ff_in;
   end

   assign byte_out = byte_ff;

   // compare the value the window holds after this shift
   assign hit = !cfg.active || !cfg.care || (byte_in == cfg.pat_byte);

endmodule

// ----- hdl/masked_byte_pattern_search.sv -----
// Masked byte pattern search.
// Request channel (req_valid/req_stall): one region byte per item, with
// req_last_byte marking the final byte of a region. An item is taken on a
// clock edge where req_valid is high and req_stall is low.
// Response channel (rsp_valid/rsp_stall): at most one item per region,
// found=1 with the start offset of the first matching position, or found=0
// with offset 0 when the region ends without a match.
// Config channel (csr_valid/csr_ready): index 0 pattern_low, 1 pattern_high,
// 2 care_mask, 3 pattern_length; other indexes are ignored. csr_ready is
// always high. Write only while no item is in flight.
// Latency: the response is registered and is valid the cycle after the byte
// that caused it is taken. Throughput: one byte per cycle while req_stall is
// low, set by the window chain which shifts and compares all cells on accept.
// A stalled response holds; req_stall rises only while a response waits and
// rsp_stall is high, so a held response blocks new bytes but nothing more.
// Reset (synchronous): clears registers to their defaults (length 1), the
// byte count and match flag, and the response valid.
module masked_byte_pattern_search #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [7:0]                            req_data_byte,
   input  logic                                  req_last_byte,
   // response channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [mbps_pkg::OUT_OFFSET_BITS-1:0]  rsp_match_offset,
   // config channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mbps_pkg::CFG_DATA_BITS-1:0]    csr_data
);

   localparam int BB = mbps_pkg::BYTE_BITS;
   localparam int IB = mbps_pkg::PAT_IDX_BITS;

   // ---------------- config registers ----------------
   logic [mbps_pkg::CFG_DATA_BITS-1:0] pattern_low_ff,  pattern_low_in;
   logic [mbps_pkg::CFG_DATA_BITS-1:0] pattern_high_ff, pattern_high_in;
   logic [mbps_pkg::MASK_BITS-1:0]     care_mask_ff,    care_mask_in;
   logic [mbps_pkg::LEN_BITS-1:0]      pattern_length_ff, pattern_length_in;
   logic                               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      care_mask_in      = care_mask_ff;
      pattern_length_in = pattern_length_ff;
      if (csr_write) begin
         case (csr_index)
            mbps_pkg::CSR_PATTERN_LOW:    pattern_low_in    = csr_data;
            mbps_pkg::CSR_PATTERN_HIGH:   pattern_high_in   = csr_data;
            mbps_pkg::CSR_CARE_MASK:      care_mask_in      =
               csr_data[mbps_pkg::MASK_BITS-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH: pattern_length_in =
               csr_data[mbps_pkg::LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '0;
         pattern_length_ff <= mbps_pkg::LENGTH_RESET;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         care_mask_ff      <= care_mask_in;
         pattern_length_ff <= pattern_length_in;
      end
   end

   // effective length minus one: 0 reads as 1, above MAX_PATTERN clamps
   logic [IB-1:0] len_m1;
   always_comb begin
      if (pattern_length_ff == '0) begin
         len_m1 = '0;
      end else if (pattern_length_ff > mbps_pkg::LEN_BITS'(MAX_PATTERN)) begin
         len_m1 = IB'(MAX_PATTERN - 1);
      end else begin
         len_m1 = IB'(pattern_length_ff - 1'b1);
      end
   end

   logic [2*mbps_pkg::CFG_DATA_BITS-1:0] pat_all;
   assign pat_all = {pattern_high_ff, pattern_low_ff};

   // ---------------- handshake ----------------
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // ---------------- window chain ----------------
   // Cell j holds window entry j (entry 0 newest) and is compared with
   // pattern byte len-1-j when j < len.
   logic [BB-1:0]        cell_byte [MAX_PATTERN];
   logic [MAX_PATTERN-1:0] cell_hit;

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      mbps_pkg::cell_cfg_type cfg;
      logic [IB-1:0]          pat_idx;
      logic [BB-1:0]          byte_in;

      assign pat_idx      = len_m1 - IB'(j);
      assign cfg.pat_byte = pat_all[pat_idx*BB +: BB];
      assign cfg.care     = care_mask_ff[pat_idx];
      assign cfg.active   = (IB'(j) <= len_m1);

      if (j == 0) begin : g_head
         assign byte_in = req_data_byte;
      end else begin : g_link
         assign byte_in = cell_byte[j-1];
      end

      mbps_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (byte_in),
         .cfg      (cfg),
         .byte_out (cell_byte[j]),
         .hit      (cell_hit[j])
      );
   end

   // ---------------- region tracking ----------------
   logic [OFFSET_BITS-1:0] seen_ff, seen_in, seen_next;
   logic                   reported_ff, reported_in;
   logic [OFFSET_BITS-1:0] len_ext;
   logic [OFFSET_BITS-1:0] off_full;
   logic [mbps_pkg::OUT_OFFSET_BITS-1:0] off_out;
   logic                   match_now;
   logic                   emit;
   logic                   emit_found;

   // count saturates at all ones
   assign seen_next = (&seen_ff) ? seen_ff : seen_ff + 1'b1;
   assign len_ext   = OFFSET_BITS'(len_m1) + 1'b1;
   assign off_full  = seen_next - len_ext;

   if (OFFSET_BITS > mbps_pkg::OUT_OFFSET_BITS) begin : g_clamp
      assign off_out = (|off_full[OFFSET_BITS-1:mbps_pkg::OUT_OFFSET_BITS]) ?
                       '1 : off_full[mbps_pkg::OUT_OFFSET_BITS-1:0];
   end else begin : g_ext
      assign off_out = mbps_pkg::OUT_OFFSET_BITS'(off_full);
   end

   assign match_now  = !reported_ff && (seen_next >= len_ext) && (&cell_hit);
   assign emit_found = match_now;
   assign emit       = match_now || (req_last_byte && !reported_ff);

   always_comb begin
      seen_in     = seen_ff;
      reported_in = reported_ff;
      if (accept) begin
         if (req_last_byte) begin
            seen_in     = '0;
            reported_in = 1'b0;
         end else begin
            seen_in     = seen_next;
            reported_in = reported_ff || match_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         reported_ff <= 1'b0;
      end else begin
         seen_ff     <= seen_in;
         reported_ff <= reported_in;
      end
   end

   // ---------------- response register ----------------
   logic                                 rsp_found_ff, rsp_found_in;
   logic [mbps_pkg::OUT_OFFSET_BITS-1:0] rsp_offset_ff, rsp_offset_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && emit) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = emit_found;
         rsp_offset_in = emit_found ? off_out : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_match_offset = rsp_offset_ff;

endmodule
